@@ src/bwwt_pkg.sv @@
// Shared types and codes for the block write window tracker.
package bwwt_pkg;

	// Field widths of the block index and of an internal block position.
	localparam int IDX_W = 31;
	localparam int POS_W = 32;

	// Action codes of an input transaction.
	localparam logic [1:0] ACT_PUT      = 2'd0;
	localparam logic [1:0] ACT_COLLECT  = 2'd1;
	localparam logic [1:0] ACT_COMPLETE = 2'd2;
	localparam logic [1:0] ACT_QUERY    = 2'd3;

	// Per-block states held in the window.
	localparam logic [1:0] BLK_EMPTY    = 2'd0;
	localparam logic [1:0] BLK_RECEIVED = 2'd1;
	localparam logic [1:0] BLK_BEING    = 2'd2;
	localparam logic [1:0] BLK_WRITTEN  = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_ISSUED = 2'd1;
	localparam logic [1:0] KIND_FIRST  = 2'd2;

	// Result status codes.
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_OUTSIDE   = 2'd1;
	localparam logic [1:0] STS_UNWRITTEN = 2'd2;
	localparam logic [1:0] STS_PRESENT   = 2'd3;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC1,
		S_DEC2,
		S_DISPATCH,
		S_PUT_TGT,
		S_PUT_CHK,
		S_PUT_CLR,
		S_COL_SKIP,
		S_COL_RUN,
		S_CMP_WR,
		S_QRY_SCAN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       dec1;
		logic       dec2;
		logic       step;
		logic       reload;
		logic       commit;
		logic       wr_en;
		logic [1:0] wr_state;
		logic       emit;
		logic [1:0] emit_kind;
		logic [1:0] emit_status;
		logic       emit_written;
		logic       emit_last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] act;
		logic       early_done;
		logic [1:0] early_status;
		logic       early_written;
		logic       put_slide;
		logic       cnt_zero;
		logic       cnt_last;
		logic [1:0] ent_state;
	} dp_sts_t;

endpackage

@@ src/bwwt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bwwt_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a colliding read returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/bwwt_dp.sv @@
// Datapath of the block write window tracker: window registers, scan pointer, state RAM.
module bwwt_dp import bwwt_pkg::*; #(
	parameter int WINDOW_SIZE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic [1:0]       action,
	input  logic [IDX_W-1:0] block_index,
	input  logic [IDX_W-1:0] range_end,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic [IDX_W-1:0] result_index,
	output logic             all_written,
	output logic [1:0]       status,
	output logic             last
);

	localparam int SW = $clog2(WINDOW_SIZE);
	localparam int CW = $clog2(WINDOW_SIZE + 1);
	localparam logic [POS_W-1:0] WIN    = POS_W'(WINDOW_SIZE);
	localparam logic [POS_W-1:0] WIN2   = POS_W'(2 * WINDOW_SIZE);
	localparam logic [POS_W-1:0] WIN_M1 = POS_W'(WINDOW_SIZE - 1);
	localparam logic [SW:0]      WRAP   = (SW + 1)'(WINDOW_SIZE);
	localparam logic [SW-1:0]    LAST_SLOT = SW'(WINDOW_SIZE - 1);
	localparam logic [CW-1:0]    CNT_FULL  = CW'(WINDOW_SIZE);

	// Captured transaction.
	logic [1:0]       act_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rend_q;

	// Window position.
	logic [IDX_W-1:0] ws_q;
	logic [SW-1:0]    wslot_q;

	// First decode stage.
	logic [POS_W-1:0] off_q;
	logic [POS_W-1:0] roff_q;
	logic             idx_lt_ws_q;
	logic             rend_lt_ws_q;
	logic             rend_lt_idx_q;

	// Second decode stage.
	logic             early_d;
	logic [1:0]       early_sts_d;
	logic             early_wr_d;
	logic             slide_d;
	logic [SW-1:0]    fo_d;
	logic [CW-1:0]    count_d;
	logic [SW:0]      slot_sum;
	logic [SW-1:0]    start_slot;
	logic             early_q;
	logic [1:0]       early_sts_q;
	logic             early_wr_q;
	logic             slide_q;
	logic [CW-1:0]    count_q;

	// Scan pointer.
	logic [SW-1:0]    cur_slot_q;
	logic [SW-1:0]    cur_slot_d;
	logic [SW-1:0]    next_slot;
	logic [CW-1:0]    cnt_q;
	logic [POS_W-1:0] pos_q;

	// State storage.
	logic [1:0]             rd_data;
	logic [WINDOW_SIZE-1:0] valid_q;
	logic                   vld_rd_q;

	// Result register.
	logic             res_valid_q;
	logic [1:0]       res_kind_q;
	logic [IDX_W-1:0] res_index_q;
	logic             res_written_q;
	logic [1:0]       res_status_q;
	logic             res_last_q;
	logic [IDX_W-1:0] emit_index;

	// Capture the transaction when it is accepted.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			idx_q  <= block_index;
			rend_q <= range_end;
		end
	end

	// Offsets from the window start and the order of the two indices.
	always_ff @(posedge clk) begin
		if (cmd.dec1) begin
			off_q         <= {1'b0, idx_q} - {1'b0, ws_q};
			roff_q        <= {1'b0, rend_q} - {1'b0, ws_q};
			idx_lt_ws_q   <= idx_q < ws_q;
			rend_lt_ws_q  <= rend_q < ws_q;
			rend_lt_idx_q <= rend_q < idx_q;
		end
	end

	// Work out the scan plan or an immediate answer for the action.
	always_comb begin
		early_d     = 1'b0;
		early_sts_d = STS_OK;
		early_wr_d  = 1'b0;
		slide_d     = 1'b0;
		fo_d        = '0;
		count_d     = '0;
		unique case (act_q)
			ACT_PUT: begin
				if (idx_lt_ws_q) begin
					early_d     = 1'b1;
					early_sts_d = STS_OUTSIDE;
				end else if (off_q < WIN) begin
					fo_d = off_q[SW-1:0];
				end else if (off_q >= WIN2) begin
					early_d     = 1'b1;
					early_sts_d = STS_UNWRITTEN;
				end else begin
					slide_d = 1'b1;
					count_d = CW'(off_q - WIN_M1);
				end
			end
			ACT_COLLECT: begin
				count_d = CNT_FULL;
			end
			ACT_COMPLETE: begin
				if (!idx_lt_ws_q && off_q > WIN) begin
					early_d     = 1'b1;
					early_sts_d = STS_OUTSIDE;
				end else if (!idx_lt_ws_q) begin
					count_d = CW'(off_q);
				end
			end
			ACT_QUERY: begin
				if (rend_lt_idx_q || rend_lt_ws_q) begin
					early_d    = 1'b1;
					early_wr_d = 1'b1;
				end else if (roff_q >= WIN) begin
					early_d = 1'b1;
				end else begin
					fo_d    = idx_lt_ws_q ? '0 : off_q[SW-1:0];
					count_d = CW'(roff_q - POS_W'(fo_d) + POS_W'(1));
				end
			end
		endcase
	end

	// Slot of the first entry to visit.
	assign slot_sum   = {1'b0, wslot_q} + {1'b0, fo_d};
	assign start_slot = (slot_sum >= WRAP) ? SW'(slot_sum - WRAP) : slot_sum[SW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.dec2) begin
			early_q     <= early_d;
			early_sts_q <= early_sts_d;
			early_wr_q  <= early_wr_d;
			slide_q     <= slide_d;
			count_q     <= count_d;
		end
	end

	// Scan pointer: the RAM is read at the next slot so that data lines up.
	assign next_slot = (cur_slot_q == LAST_SLOT) ? '0 : cur_slot_q + SW'(1);

	always_comb begin
		priority if (cmd.dec2) begin
			cur_slot_d = start_slot;
		end else if (cmd.reload) begin
			cur_slot_d = wslot_q;
		end else if (cmd.step) begin
			cur_slot_d = next_slot;
		end else begin
			cur_slot_d = cur_slot_q;
		end
	end

	always_ff @(posedge clk) begin
		cur_slot_q <= cur_slot_d;
		priority if (cmd.dec2) begin
			cnt_q <= count_d;
			pos_q <= {1'b0, ws_q};
		end else if (cmd.reload) begin
			cnt_q <= count_q;
			pos_q <= {1'b0, ws_q};
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CW'(1);
			pos_q <= pos_q + POS_W'(1);
		end
	end

	// Window start moves once a slide has cleared every block it passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= '0;
			wslot_q <= '0;
		end else if (cmd.commit) begin
			ws_q    <= pos_q[IDX_W-1:0];
			wslot_q <= cur_slot_q;
		end
	end

	// Block state storage; entries never written since reset read as empty.
	bwwt_ram #(
		.WIDTH(2),
		.DEPTH(WINDOW_SIZE)
	) u_state_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(cur_slot_q),
		.wdata(cmd.wr_state),
		.raddr(cur_slot_d),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				valid_q[cur_slot_q] <= 1'b1;
			end
			vld_rd_q <= valid_q[cur_slot_d];
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.act           = act_q;
		sts.early_done    = early_q;
		sts.early_status  = early_sts_q;
		sts.early_written = early_wr_q;
		sts.put_slide     = slide_q;
		sts.cnt_zero      = (cnt_q == '0);
		sts.cnt_last      = (cnt_q == CW'(1));
		sts.ent_state     = vld_rd_q ? rd_data : BLK_EMPTY;
	end

	// Result index: issued block, saturated first unwritable block, or zero.
	always_comb begin
		priority if (cmd.emit_kind == KIND_ISSUED) begin
			emit_index = pos_q[IDX_W-1:0];
		end else if (cmd.emit_kind == KIND_FIRST) begin
			emit_index = pos_q[POS_W-1] ? '1 : pos_q[IDX_W-1:0];
		end else begin
			emit_index = '0;
		end
	end

	// Result register: each result is shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_kind_q    <= cmd.emit_kind;
			res_index_q   <= emit_index;
			res_written_q <= cmd.emit_written;
			res_status_q  <= cmd.emit_status;
			res_last_q    <= cmd.emit_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign result_index = res_index_q;
	assign all_written  = res_written_q;
	assign status       = res_status_q;
	assign last         = res_last_q;

endmodule

@@ src/bwwt_ctl.sv @@
// Controller of the block write window tracker: sequences decode, scans and results.
module bwwt_ctl import bwwt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC1;
				end
			end
			S_DEC1: begin
				cmd.dec1 = 1'b1;
				state_d  = S_DEC2;
			end
			S_DEC2: begin
				cmd.dec2 = 1'b1;
				state_d  = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (sts.early_done) begin
					cmd.emit         = 1'b1;
					cmd.emit_kind    = KIND_ACK;
					cmd.emit_status  = sts.early_status;
					cmd.emit_written = sts.early_written;
					cmd.emit_last    = 1'b1;
					state_d          = S_IDLE;
				end else begin
					unique case (sts.act)
						ACT_PUT:      state_d = sts.put_slide ? S_PUT_CHK : S_PUT_TGT;
						ACT_COLLECT:  state_d = S_COL_SKIP;
						ACT_COMPLETE: state_d = S_CMP_WR;
						ACT_QUERY:    state_d = S_QRY_SCAN;
					endcase
				end
			end
			S_PUT_TGT: begin
				cmd.emit      = 1'b1;
				cmd.emit_kind = KIND_ACK;
				cmd.emit_last = 1'b1;
				if (sts.ent_state != BLK_EMPTY) begin
					cmd.emit_status = STS_PRESENT;
				end else begin
					cmd.wr_en       = 1'b1;
					cmd.wr_state    = BLK_RECEIVED;
					cmd.emit_status = STS_OK;
				end
				state_d = S_IDLE;
			end
			S_PUT_CHK: begin
				// Every block that slides out must already be written.
				if (sts.cnt_zero) begin
					cmd.reload = 1'b1;
					state_d    = S_PUT_CLR;
				end else if (sts.ent_state != BLK_WRITTEN) begin
					cmd.emit        = 1'b1;
					cmd.emit_kind   = KIND_ACK;
					cmd.emit_status = STS_UNWRITTEN;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_PUT_CLR: begin
				// The last cleared slot is the slot of the new block.
				if (sts.cnt_zero) begin
					cmd.commit      = 1'b1;
					cmd.emit        = 1'b1;
					cmd.emit_kind   = KIND_ACK;
					cmd.emit_status = STS_OK;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.wr_en    = 1'b1;
					cmd.wr_state = sts.cnt_last ? BLK_RECEIVED : BLK_EMPTY;
					cmd.step     = 1'b1;
				end
			end
			S_COL_SKIP: begin
				if (sts.cnt_zero) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FIRST;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end else if (sts.ent_state == BLK_WRITTEN || sts.ent_state == BLK_BEING) begin
					cmd.step = 1'b1;
				end else begin
					state_d = S_COL_RUN;
				end
			end
			S_COL_RUN: begin
				if (!sts.cnt_zero && sts.ent_state == BLK_RECEIVED) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_state  = BLK_BEING;
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_ISSUED;
					cmd.step      = 1'b1;
				end else begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FIRST;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_CMP_WR: begin
				if (sts.cnt_zero) begin
					cmd.emit        = 1'b1;
					cmd.emit_kind   = KIND_ACK;
					cmd.emit_status = STS_OK;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.wr_en    = 1'b1;
					cmd.wr_state = BLK_WRITTEN;
					cmd.step     = 1'b1;
				end
			end
			S_QRY_SCAN: begin
				if (sts.cnt_zero || sts.ent_state != BLK_WRITTEN) begin
					cmd.emit         = 1'b1;
					cmd.emit_kind    = KIND_ACK;
					cmd.emit_written = sts.cnt_zero;
					cmd.emit_last    = 1'b1;
					state_d          = S_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// The final result of a transaction hands control back to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> (state_q == S_IDLE))
		else $error("final result did not return the controller to idle");

	// The scan pointer never advances past its planned count.
	a_step_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !sts.cnt_zero)
		else $error("scan stepped with no entries left");

	// An accepted transaction always enters decode.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q == S_DEC1))
		else $error("accepted transaction did not enter decode");

	// An issued block is never the final result of a collect.
	a_issued_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_kind == KIND_ISSUED) |-> !cmd.emit_last)
		else $error("issued block marked as final result");
`endif

endmodule

@@ src/block_write_window_tracker_core.sv @@
// Top level of the block write window tracker: controller plus datapath.
//
// Usage: a transaction (action, block_index, range_end) is accepted at a rising
// edge where start is high and busy is low. The block works on one transaction
// at a time and raises busy until its final result has been issued.
// Results leave on result_kind, result_index, all_written, status and last,
// each marked by result_valid for exactly one cycle; the receiver cannot stall
// them. The result with last set closes the transaction.
// Sequence: decode in S_DEC1 and S_DEC2, dispatch, then the scan. An answer
// found without a scan is given from the dispatch state. A put into the window
// writes its slot directly; a put that slides first checks that every block
// sliding out is written, then clears those blocks. A collect skips written and
// in-progress entries and issues each received block that follows; a complete
// marks its blocks written and a query stops at the first unwritten block. The
// state RAM is walked one entry per cycle while a scan steps.
// A new transaction can be accepted in the cycle its final result is shown.
// Reset empties every block and sets the window start to zero; it needs no
// clearing pass.
module block_write_window_tracker_core import bwwt_pkg::*; #(
	parameter int WINDOW_SIZE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       action,
	input  logic [IDX_W-1:0] block_index,
	input  logic [IDX_W-1:0] range_end,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic [IDX_W-1:0] result_index,
	output logic             all_written,
	output logic [1:0]       status,
	output logic             last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencing of each transaction.
	bwwt_ctl u_ctl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	// Window state and result formatting.
	bwwt_dp #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.block_index (block_index),
		.range_end   (range_end),
		.result_valid(result_valid),
		.result_kind (result_kind),
		.result_index(result_index),
		.all_written (all_written),
		.status      (status),
		.last        (last)
	);

endmodule
